### rtl/wildcard_glob_matcher_assert.svh
// assertion macros for the glob matcher
`ifndef WILDCARD_GLOB_MATCHER_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, off while reset is low
`define WGM_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("glob matcher assertion failed");

// next-cycle implication, off while reset is low
`define WGM_ASSERT_NXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("glob matcher assertion failed");

`else

`define WGM_ASSERT_IMP(label, clk, rstn, pre, post)
`define WGM_ASSERT_NXT(label, clk, rstn, pre, post)

`endif

`endif

### rtl/wgm_pkg.sv
`timescale 1ns / 1ps

package wgm_pkg;

    localparam int PATTERN_LEN_DEF = 32;
    localparam int PAT_REG_BYTES   = 32;
    localparam int PAT_REG_COUNT   = 4;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_LEN_W       = 6;

    localparam logic [7:0] STAR_CHAR  = 8'h2A;
    localparam logic [7:0] QMARK_CHAR = 8'h3F;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_Z    = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    localparam logic [CFG_INDEX_W-1:0] REG_PAT_0    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAT_1    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAT_2    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PAT_3    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PAT_LEN  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CASE_SEN = 3'd5;

    // upper-case folding of ascii letters when case_sens is clear
    function automatic logic [7:0] fold_char(input logic [7:0] c, input logic case_sens);
        logic [7:0] r;
        r = c;
        if (!case_sens && c >= LOWER_A && c <= LOWER_Z) begin
            r = c - CASE_DIFF;
        end
        return r;
    endfunction

endpackage

### rtl/wildcard_glob_matcher.sv
`timescale 1ns / 1ps
// wildcard glob matcher: '*' takes any run of characters, '?' exactly one.
// s_ channel carries the text, one character per item; s_tuser[0] says the
// character in s_tdata is present (clear for the end-only item of an empty text)
// and s_tlast ends the text. only a last item gives a result on the m_ channel:
// m_tdata[0] is 1 when the whole text matched the whole pattern.
// cfg channel writes the registers: index 0..3 pattern bytes (eight per
// register, lowest byte first), 4 pattern length, 5 case-sensitive flag.
// cfg_ready is always high; writes belong between texts or between items.
// a last item passes through the input register, then the result register.
// throughput: one item per cycle while s_tready is high, set by the combinational
// update of the active-position vector (compare, shift and two star closures).
// reset clears the registers, the item and result stages, and puts the
// matcher at pattern position zero. a stalled result holds in the result
// register; a further last item waits in the input register until it drains,
// and s_tready drops only while that input register cannot move on.
// after each last item the matcher goes back to position zero.
module wildcard_glob_matcher
    import wgm_pkg::*;
#(
    parameter int PATTERN_LEN = PATTERN_LEN_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] text_byte
    input  logic                   s_tuser,   // [0] has_byte
    input  logic                   s_tlast,   // last_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [0] matched, [7:1] zero
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

`include "wildcard_glob_matcher_assert.svh"

    localparam int N     = PATTERN_LEN;
    localparam int LEN_W = $clog2(N + 1);
    localparam int LVLS  = $clog2(N + 1);
    localparam logic [N:0] START_POS = (N + 1)'(1);

    // configuration
    logic [CFG_DATA_W-1:0] pat_reg [PAT_REG_COUNT];
    logic [CFG_LEN_W-1:0]  len_reg;
    logic                  case_reg;

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_has_reg;
    logic       in_last_reg;

    // matcher state and result
    logic [N:0] state_reg, state_next;
    logic       out_valid_reg;
    logic       out_match_reg, out_match_next;

    logic             consume;
    logic [LEN_W-1:0] eff_len;
    logic [7:0]       pat_byte [N];
    logic [N-1:0]     star_vec;
    logic [N-1:0]     hit_vec;
    logic [N:0]       keep_vec;
    logic [N:0]       cur_pos;
    logic [N:0]       step_pos;
    logic [N:0]       new_pos;
    logic [7:0]       text_fold;

    // closure over runs of '*' as a parallel prefix, then drop positions past the end
    function automatic logic [N:0] star_close(input logic [N:0] s, input logic [N-1:0] star,
                                              input logic [N:0] keep);
        logic [N:0] c;
        logic [N:0] p;
        c = s;
        p = {1'b0, star};
        for (int l = 0; l < LVLS; l++) begin
            c = c | ((c & p) << (1 << l));
            p = p & (p >> (1 << l));
        end
        return c & keep;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < PAT_REG_COUNT; r++) begin
                pat_reg[r] <= '0;
            end
            len_reg  <= '0;
            case_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PAT_0:    pat_reg[0] <= cfg_data;
                REG_PAT_1:    pat_reg[1] <= cfg_data;
                REG_PAT_2:    pat_reg[2] <= cfg_data;
                REG_PAT_3:    pat_reg[3] <= cfg_data;
                REG_PAT_LEN:  len_reg    <= cfg_data[CFG_LEN_W-1:0];
                REG_CASE_SEN: case_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // only a last item needs room in the result register
    assign consume  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_has_reg  <= s_tuser;
            in_last_reg <= s_tlast;
        end
    end

    // pattern layout, effective length and per-position compare
    always_comb begin
        if (int'(len_reg) > N) begin
            eff_len = LEN_W'(N);
        end else begin
            eff_len = LEN_W'(len_reg);
        end
        text_fold = fold_char(in_byte_reg, case_reg);
        for (int i = 0; i < N; i++) begin
            if (i < PAT_REG_BYTES) begin
                pat_byte[i] = pat_reg[i >> 3][(i & 7) * 8 +: 8];
            end else begin
                pat_byte[i] = 8'h00;
            end
            star_vec[i] = (pat_byte[i] == STAR_CHAR) && (i < int'(eff_len));
            hit_vec[i]  = (pat_byte[i] != STAR_CHAR) && (i < int'(eff_len)) &&
                          ((pat_byte[i] == QMARK_CHAR) ||
                           (fold_char(pat_byte[i], case_reg) == text_fold));
        end
        for (int i = 0; i <= N; i++) begin
            keep_vec[i] = (i <= int'(eff_len));
        end
    end

    // one character advance of the position vector
    always_comb begin
        cur_pos  = star_close(state_reg, star_vec, keep_vec);
        step_pos = ({1'b0, cur_pos[N-1:0] & star_vec}) |
                   ({cur_pos[N-1:0] & hit_vec, 1'b0});
        new_pos  = in_has_reg ? star_close(step_pos, star_vec, keep_vec) : cur_pos;

        state_next     = state_reg;
        out_match_next = out_match_reg;
        if (consume) begin
            if (in_last_reg) begin
                state_next     = START_POS;
                out_match_next = new_pos[eff_len];
            end else begin
                state_next = new_pos;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= START_POS;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (consume && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_match_reg <= out_match_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_match_reg};

    `WGM_ASSERT_NXT(a_restart_after_last, aclk, aresetn,
        consume && in_last_reg, state_reg == START_POS)
    `WGM_ASSERT_NXT(a_result_after_last, aclk, aresetn,
        consume && in_last_reg, out_valid_reg)
    `WGM_ASSERT_NXT(a_input_held, aclk, aresetn,
        in_valid_reg && !consume, in_valid_reg && $stable(in_byte_reg) && $stable(in_last_reg))
    `WGM_ASSERT_IMP(a_no_consume_on_stall, aclk, aresetn,
        out_valid_reg && !m_tready && in_last_reg, !consume)

endmodule
